// ===== rtl/ccull_pkg.sv =====
// Shared constants, field layouts and the queue entry type for the chunk cull block.
`timescale 1ns / 1ps
`default_nettype none

package ccull_pkg;

    // Chunk geometry
    localparam int CHUNK_WIDTH  = 16;
    localparam int CHUNK_HEIGHT = 256;

    // Field widths
    localparam int MODE_W   = 2;
    localparam int COORD_W  = 13;
    localparam int COUNT_W  = 24;
    localparam int BLOCK_W  = 17;
    localparam int ORIGIN_W = 17;
    localparam int CHUNKS_W = 16;
    localparam int BTOT_W   = 32;

    // List selector codes (the fourth code acts as combined)
    localparam logic [MODE_W-1:0] MODE_OPAQUE   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_WATER    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_COMBINED = 2'd2;

    // Configuration register indexes
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_LEFT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_RIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_BOTTOM = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_TOP    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_NEAR   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_FAR    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_VIEW_SETUP   = 3'd6;
    localparam int NUM_PLANES = 6;

    // Plane register layout: nx, ny, nz Q1.10, d Q17.10
    localparam int PLANE_W = 64;
    localparam int NRM_W   = 12;
    localparam int DIST_W  = 28;
    localparam int NX_LSB  = 0;
    localparam int NY_LSB  = 12;
    localparam int NZ_LSB  = 24;
    localparam int D_LSB   = 36;

    // View setup layout
    localparam int VIEW_W       = 40;
    localparam int CAM_W        = 16;
    localparam int CAMX_LSB     = 0;
    localparam int CAMZ_LSB     = 16;
    localparam int RAD_W        = 6;
    localparam int RAD_LSB      = 32;
    localparam int DIST_EN_BIT  = 38;
    localparam int FRUST_EN_BIT = 39;

    // Box arithmetic widths
    localparam int CW_W    = $clog2(CHUNK_WIDTH + 1);
    localparam int CH_W    = $clog2(CHUNK_HEIGHT + 1);
    localparam int V_W     = COORD_W + CW_W + 1;
    localparam int PROD_W  = NRM_W + V_W;
    localparam int YPROD_W = NRM_W + CH_W + 1;
    localparam int SUM_BASE = (PROD_W > DIST_W) ? PROD_W : DIST_W;
    localparam int SUM_W   = SUM_BASE + 2;

    // Distance arithmetic widths
    localparam int DX_W   = CAM_W + 1;
    localparam int SQ_W   = 2 * DX_W;
    localparam int DSUM_W = SQ_W + 1;
    localparam int RSQ_W  = 2 * RAD_W;

    // Input stream layout
    localparam int S_CX_LSB    = 0;
    localparam int S_CZ_LSB    = S_CX_LSB + COORD_W;
    localparam int S_OC_LSB    = S_CZ_LSB + COORD_W;
    localparam int S_WC_LSB    = S_OC_LSB + COUNT_W;
    localparam int S_BC_LSB    = S_WC_LSB + COUNT_W;
    localparam int S_FIELDS_W  = S_BC_LSB + BLOCK_W;
    localparam int S_TDATA_W   = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int S_MODE_LSB  = 0;
    localparam int S_FS_BIT    = S_MODE_LSB + MODE_W;
    localparam int S_TUSER_W   = ((S_FS_BIT + 1 + 7) / 8) * 8;

    // Result stream layout
    localparam int M_OX_LSB    = 0;
    localparam int M_OZ_LSB    = M_OX_LSB + ORIGIN_W;
    localparam int M_OC_LSB    = M_OZ_LSB + ORIGIN_W;
    localparam int M_WC_LSB    = M_OC_LSB + COUNT_W;
    localparam int M_BC_LSB    = M_WC_LSB + COUNT_W;
    localparam int M_CT_LSB    = M_BC_LSB + BLOCK_W;
    localparam int M_BT_LSB    = M_CT_LSB + CHUNKS_W;
    localparam int M_FIELDS_W  = M_BT_LSB + BTOT_W;
    localparam int M_TDATA_W   = ((M_FIELDS_W + 7) / 8) * 8;

    // Queue between classifier and tally unit (depth is a power of two)
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = QPTR_W + 1;

    // One classified chunk on its way to the tally unit
    typedef struct packed {
        logic                keep;   // emit a draw item
        logic                tally;  // counts toward the frame totals
        logic                clear;  // clear the totals first
        logic [ORIGIN_W-1:0] origin_x;
        logic [ORIGIN_W-1:0] origin_z;
        logic [COUNT_W-1:0]  opaque_out;
        logic [COUNT_W-1:0]  water_out;
        logic [BLOCK_W-1:0]  blocks_out;
    } qent_t;

endpackage

`default_nettype wire

// ===== rtl/ccull_front.sv =====
// Classifier: holds the plane and view registers, runs the empty, distance and plane tests.
`timescale 1ns / 1ps
`default_nettype none

module ccull_front (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_valid,
    input  wire logic [ccull_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [ccull_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [ccull_pkg::S_TDATA_W-1:0]  s_tdata,
    input  wire logic [ccull_pkg::S_TUSER_W-1:0]  s_tuser,
    output logic                                  push_valid,
    input  wire logic                             push_ready,
    output ccull_pkg::qent_t                      push_data
);
    import ccull_pkg::*;

    localparam logic signed [V_W-1:0]     CW_V = V_W'(CHUNK_WIDTH);
    localparam logic signed [YPROD_W-1:0] CH_Y = YPROD_W'(CHUNK_HEIGHT);

    // Configuration registers
    logic [PLANE_W-1:0] plane_reg [NUM_PLANES];
    logic [VIEW_W-1:0]  view_reg;

    // Input field views
    logic [MODE_W-1:0]         in_mode;
    logic                      in_fs;
    logic signed [COORD_W-1:0] in_cx;
    logic signed [COORD_W-1:0] in_cz;
    logic [COUNT_W-1:0]        in_oc;
    logic [COUNT_W-1:0]        in_wc;
    logic [BLOCK_W-1:0]        in_bc;
    logic                      water_only;

    // Stage A combinational
    logic signed [V_W-1:0]     x0, z0, x1, z1;
    logic signed [CAM_W-1:0]   cam_x, cam_z;
    logic signed [DX_W-1:0]    dx, dz;
    logic signed [SQ_W-1:0]    dx_w, dz_w;
    logic [RAD_W-1:0]          rad;
    logic                      nonempty_next;
    logic [SQ_W-1:0]           dx2_next, dz2_next;
    logic [RSQ_W-1:0]          rsq_next;
    logic signed [PROD_W-1:0]  px_next [NUM_PLANES];
    logic signed [YPROD_W-1:0] py_next [NUM_PLANES];
    logic signed [PROD_W-1:0]  pz_next [NUM_PLANES];
    qent_t                     a_item_next;

    // Stage A registers
    logic                      a_valid_reg;
    logic                      a_nonempty_reg;
    logic [SQ_W-1:0]           a_dx2_reg, a_dz2_reg;
    logic [RSQ_W-1:0]          a_rsq_reg;
    logic signed [PROD_W-1:0]  a_px_reg [NUM_PLANES];
    logic signed [YPROD_W-1:0] a_py_reg [NUM_PLANES];
    logic signed [PROD_W-1:0]  a_pz_reg [NUM_PLANES];
    qent_t                     a_item_reg;

    // Stage B combinational and registers
    logic [NUM_PLANES-1:0]     plane_in;
    logic [DSUM_W-1:0]         dsum;
    logic                      dist_ok, frust_ok;
    qent_t                     b_item_next;
    logic                      b_valid_reg;
    qent_t                     b_item_reg;
    logic                      b_need;
    logic                      adv;

    // Configuration writes; an index past the list is dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_PLANES; i++) begin
                plane_reg[i] <= '0;
            end
            view_reg <= '0;
        end else if (cfg_valid) begin
            for (int i = 0; i < NUM_PLANES; i++) begin
                if (cfg_index == CFG_IDX_W'(REG_PLANE_LEFT + i)) begin
                    plane_reg[i] <= cfg_data;
                end
            end
            if (cfg_index == REG_VIEW_SETUP) begin
                view_reg <= cfg_data[VIEW_W-1:0];
            end
        end
    end

    assign in_mode    = s_tuser[S_MODE_LSB +: MODE_W];
    assign in_fs      = s_tuser[S_FS_BIT];
    assign in_cx      = s_tdata[S_CX_LSB +: COORD_W];
    assign in_cz      = s_tdata[S_CZ_LSB +: COORD_W];
    assign in_oc      = s_tdata[S_OC_LSB +: COUNT_W];
    assign in_wc      = s_tdata[S_WC_LSB +: COUNT_W];
    assign in_bc      = s_tdata[S_BC_LSB +: BLOCK_W];
    assign water_only = (in_mode == MODE_WATER);

    // Box corners in world units
    assign x0 = V_W'(in_cx) * CW_V;
    assign z0 = V_W'(in_cz) * CW_V;
    assign x1 = x0 + CW_V;
    assign z1 = z0 + CW_V;

    assign cam_x    = view_reg[CAMX_LSB +: CAM_W];
    assign cam_z    = view_reg[CAMZ_LSB +: CAM_W];
    assign rad      = view_reg[RAD_LSB +: RAD_W];
    assign dx       = DX_W'(in_cx) - DX_W'(cam_x);
    assign dz       = DX_W'(in_cz) - DX_W'(cam_z);
    assign dx_w     = SQ_W'(dx);
    assign dz_w     = SQ_W'(dz);
    assign dx2_next = dx_w * dx_w;
    assign dz2_next = dz_w * dz_w;
    assign rsq_next = RSQ_W'(rad) * RSQ_W'(rad);

    always_comb begin
        unique case (in_mode)
            MODE_OPAQUE: nonempty_next = (in_oc != '0);
            MODE_WATER:  nonempty_next = (in_wc != '0);
            default:     nonempty_next = (in_oc != '0) || (in_wc != '0);
        endcase
    end

    // Positive-vertex products, one lane per plane
    always_comb begin
        logic signed [NRM_W-1:0]   nx, ny, nz;
        logic signed [PROD_W-1:0]  nx_e, nz_e, vx_e, vz_e;
        logic signed [YPROD_W-1:0] ny_e;
        for (int p = 0; p < NUM_PLANES; p++) begin
            nx   = plane_reg[p][NX_LSB +: NRM_W];
            ny   = plane_reg[p][NY_LSB +: NRM_W];
            nz   = plane_reg[p][NZ_LSB +: NRM_W];
            nx_e = PROD_W'(nx);
            nz_e = PROD_W'(nz);
            ny_e = YPROD_W'(ny);
            vx_e = PROD_W'(nx[NRM_W-1] ? x0 : x1);
            vz_e = PROD_W'(nz[NRM_W-1] ? z0 : z1);
            px_next[p] = nx_e * vx_e;
            pz_next[p] = nz_e * vz_e;
            py_next[p] = ny[NRM_W-1] ? '0 : ny_e * CH_Y;
        end
    end

    always_comb begin
        a_item_next            = '0;
        a_item_next.tally      = !water_only;
        a_item_next.clear      = !water_only && in_fs;
        a_item_next.origin_x   = ORIGIN_W'(x0);
        a_item_next.origin_z   = ORIGIN_W'(z0);
        a_item_next.opaque_out = (in_mode == MODE_WATER) ? '0 : in_oc;
        a_item_next.water_out  = (in_mode == MODE_OPAQUE) ? '0 : in_wc;
        a_item_next.blocks_out = water_only ? '0 : in_bc;
    end

    // The whole front stalls only when a stage-B item must enter a full queue
    assign b_need     = b_item_reg.keep || b_item_reg.clear;
    assign push_valid = b_valid_reg && b_need;
    assign push_data  = b_item_reg;
    assign adv        = !b_valid_reg || !b_need || push_ready;
    assign s_tready   = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else if (adv) begin
            a_valid_reg <= s_tvalid;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            a_nonempty_reg <= nonempty_next;
            a_dx2_reg      <= dx2_next;
            a_dz2_reg      <= dz2_next;
            a_rsq_reg      <= rsq_next;
            a_item_reg     <= a_item_next;
            for (int p = 0; p < NUM_PLANES; p++) begin
                a_px_reg[p] <= px_next[p];
                a_py_reg[p] <= py_next[p];
                a_pz_reg[p] <= pz_next[p];
            end
            b_item_reg <= b_item_next;
        end
    end

    // Stage B: plane sums and the keep decision
    always_comb begin
        logic signed [SUM_W-1:0]  sum;
        logic signed [DIST_W-1:0] d;
        for (int p = 0; p < NUM_PLANES; p++) begin
            d   = plane_reg[p][D_LSB +: DIST_W];
            sum = SUM_W'(a_px_reg[p]) + SUM_W'(a_py_reg[p]) + SUM_W'(a_pz_reg[p])
                + SUM_W'(d);
            plane_in[p] = !sum[SUM_W-1];
        end
    end

    assign dsum     = DSUM_W'(a_dx2_reg) + DSUM_W'(a_dz2_reg);
    assign dist_ok  = !view_reg[DIST_EN_BIT] || (dsum <= DSUM_W'(a_rsq_reg));
    assign frust_ok = !view_reg[FRUST_EN_BIT] || (&plane_in);

    always_comb begin
        b_item_next      = a_item_reg;
        b_item_next.keep = a_nonempty_reg && dist_ok && frust_ok;
    end

endmodule

`default_nettype wire

// ===== rtl/ccull_queue.sv =====
// Short queue of classified chunks between the classifier and the tally unit.
`timescale 1ns / 1ps
`default_nettype none

module ccull_queue (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     push_valid,
    output logic          push_ready,
    input  wire ccull_pkg::qent_t push_data,
    output logic          pop_valid,
    input  wire logic     pop_ready,
    output ccull_pkg::qent_t pop_data
);
    import ccull_pkg::*;

    qent_t             mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_push, do_pop;

    assign push_ready = (count_reg != QCNT_W'(QDEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ccull_back.sv =====
// Tally unit: keeps the saturating frame totals and drives the registered result stream.
`timescale 1ns / 1ps
`default_nettype none

module ccull_back (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            pop_valid,
    output logic                                 pop_ready,
    input  wire ccull_pkg::qent_t                pop_data,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [ccull_pkg::M_TDATA_W-1:0]      m_tdata
);
    import ccull_pkg::*;

    logic [CHUNKS_W-1:0]  chunks_tot_reg, chunks_tot_next;
    logic [BTOT_W-1:0]    blocks_tot_reg, blocks_tot_next;
    logic [CHUNKS_W-1:0]  chunks_base;
    logic [BTOT_W-1:0]    blocks_base;
    logic [BTOT_W:0]      blocks_sum;
    logic                 out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg, out_data_next;
    logic                 fire;

    assign pop_ready = !out_valid_reg || m_tready;
    assign fire      = pop_valid && pop_ready;

    assign chunks_base = pop_data.clear ? '0 : chunks_tot_reg;
    assign blocks_base = pop_data.clear ? '0 : blocks_tot_reg;
    assign blocks_sum  = {1'b0, blocks_base} + (BTOT_W + 1)'(pop_data.blocks_out);

    always_comb begin
        chunks_tot_next = chunks_base;
        blocks_tot_next = blocks_base;
        if (pop_data.keep && pop_data.tally) begin
            if (chunks_base != '1) begin
                chunks_tot_next = chunks_base + 1'b1;
            end
            blocks_tot_next = blocks_sum[BTOT_W] ? '1 : blocks_sum[BTOT_W-1:0];
        end
    end

    always_comb begin
        out_data_next                           = '0;
        out_data_next[M_OX_LSB +: ORIGIN_W]     = pop_data.origin_x;
        out_data_next[M_OZ_LSB +: ORIGIN_W]     = pop_data.origin_z;
        out_data_next[M_OC_LSB +: COUNT_W]      = pop_data.opaque_out;
        out_data_next[M_WC_LSB +: COUNT_W]      = pop_data.water_out;
        out_data_next[M_BC_LSB +: BLOCK_W]      = pop_data.blocks_out;
        out_data_next[M_CT_LSB +: CHUNKS_W]     = chunks_tot_next;
        out_data_next[M_BT_LSB +: BTOT_W]       = blocks_tot_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chunks_tot_reg <= '0;
            blocks_tot_reg <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (fire) begin
                chunks_tot_reg <= chunks_tot_next;
                blocks_tot_reg <= blocks_tot_next;
            end
            if (fire && pop_data.keep) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && pop_data.keep) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

// ===== rtl/chunk_frustum_distance_cull.sv =====
// Top level of the chunk visibility filter: classifier, queue and tally unit.
// Path: a chunk passes the stage-A and stage-B registers, the queue and the result register.
// Throughput: one chunk per cycle unless a chunk that must be queued meets a full queue, set by
//   the two-stage classifier pipeline and the tally update; the 4-entry queue absorbs result-side stalls.
// Reset: synchronous, active low; clears configuration registers, totals, queue and valid flags.
`timescale 1ns / 1ps
`default_nettype none

module chunk_frustum_distance_cull (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // Configuration write channel
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [ccull_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [ccull_pkg::CFG_DATA_W-1:0] cfg_data,
    // Chunk records in
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // tdata: chunk_x, chunk_z, opaque_count, water_count, block_count, zero pad
    input  wire logic [ccull_pkg::S_TDATA_W-1:0]  s_tdata,
    // tuser: mode, frame_start, zero pad
    input  wire logic [ccull_pkg::S_TUSER_W-1:0]  s_tuser,
    // Draw items out
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // tdata: origin_x, origin_z, opaque_out, water_out, blocks_out,
    //        chunks_total, blocks_total, zero pad
    output logic [ccull_pkg::M_TDATA_W-1:0]       m_tdata
);
    import ccull_pkg::*;

    logic  push_valid, push_ready;
    qent_t push_data;
    logic  pop_valid, pop_ready;
    qent_t pop_data;

    // Register writes never stall; the user must write only while the block is idle, the block does not enforce it
    assign cfg_ready = 1'b1;

    // Classify: drop empty meshes and, when enabled, chunks past the view radius or outside a plane.
    // Culled chunks that start a frame, outside water-only mode, still travel on so the totals clear in order.
    ccull_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // Decouple the classifier from result back-pressure
    ccull_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // Advance the frame totals in order and register each draw item
    ccull_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

`default_nettype wire

// ===== rtl/ccull_check.sv =====
// Port-level checks for the chunk cull block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module ccull_check (
    input wire logic                             aclk,
    input wire logic                             aresetn,
    input wire logic                             m_tvalid,
    input wire logic                             m_tready,
    input wire logic [ccull_pkg::M_TDATA_W-1:0]  m_tdata
);
    import ccull_pkg::*;

    logic [BLOCK_W-1:0]  blocks_out;
    logic [CHUNKS_W-1:0] chunks_total;
    logic [BTOT_W-1:0]   blocks_total;

    assign blocks_out   = m_tdata[M_BC_LSB +: BLOCK_W];
    assign chunks_total = m_tdata[M_CT_LSB +: CHUNKS_W];
    assign blocks_total = m_tdata[M_BT_LSB +: BTOT_W];

    // A stalled draw item holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("draw item changed while stalled");

    // Reset empties the result register
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // A counted chunk with blocks has bumped the chunk total
    a_chunk_counted: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (blocks_out != '0) |-> (chunks_total != '0))
        else $error("chunk total zero for a counted chunk");

    // The block total includes this chunk's blocks (saturation keeps it at least that)
    a_block_counted: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (blocks_out != '0) |-> (blocks_total >= BTOT_W'(blocks_out)))
        else $error("block total below this chunk's block count");

endmodule

bind chunk_frustum_distance_cull ccull_check u_ccull_check (.*);

`default_nettype wire
